// ----- sv/salc_pkg.sv -----
// Shared types and constants for the set-associative LRU cache tag store.
`timescale 1ns / 1ps

package salc_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_SET_BITS_DEF = 8;
    localparam int WAYS_DEF         = 8;
    localparam int COUNT_WIDTH_DEF  = 32;

    // Fixed field widths
    localparam int ADDR_W   = 64;
    localparam int ACTION_W = 2;
    localparam int TOTAL_W  = 32;
    // Set and offset fields are each at least one bit wide, so at most 62 tag bits remain
    localparam int TAG_W    = ADDR_W - 2;

    // Configuration port
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 6;
    localparam int SET_BITS_W      = 4;
    localparam int OFFSET_BITS_W   = 6;
    localparam int WAYS_USED_W     = 4;
    localparam int OFFSET_BITS_MAX = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd2;

    localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 4'd4;
    localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 6'd4;
    localparam logic [WAYS_USED_W-1:0]   WAYS_USED_RST   = 4'd1;

    // Access kinds
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   address;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         hits_added;
        logic               missed;
        logic               evicted;
        logic [TOTAL_W-1:0] hit_total;
        logic [TOTAL_W-1:0] miss_total;
        logic [TOTAL_W-1:0] eviction_total;
    } t_out_beat;

endpackage

// ----- sv/set_assoc_lru_cache_tags.sv -----
// Tag store and LRU replacement of a set-associative cache, with hit/miss/eviction totals.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one access per beat:
//   a load, store or modify and its 64-bit byte address. Output channel
//   (o_out_valid / i_out_stall / o_out_data) returns one result beat per access:
//   hits of this access, miss and eviction flags and the saturating running totals.
//   Each set is one row of a single-port-style synchronous memory (one read, one
//   write per cycle). The accept cycle issues the row read; in the S_LOOK state
//   the block compares tags, picks the way, writes the row back and loads the
//   result register. The input stalls in S_LOOK, so a new access is taken only
//   once the last one has finished; a modify costs no extra row access.
//   The result register lets the next access be taken while a result waits. If a
//   result is still stalled when the next one is ready, the block holds the finished
//   access (and stalls its input) until the output beat is taken.
//   Reset clears the totals, restores set_bits 4, offset_bits 4, ways_used 1, and
//   marks every set row empty through one flag per row; no clearing pass is needed,
//   so the block can take an access as soon as reset is released.
//   Configuration writes are taken at any time but are meant for an idle block.
module set_assoc_lru_cache_tags
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int WAYS         = WAYS_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // access channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W     = $clog2(WAYS + 1);
    localparam int WIDX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [WAYS-1:0]              valid;
        logic [WAYS-1:0][TAG_W-1:0]   tag;
        logic [WAYS-1:0][RANK_W-1:0]  rank;
    } t_row;

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    // Configuration and control state
    t_state                      r_state;
    logic [SET_BITS_W-1:0]       r_set_bits;
    logic [OFFSET_BITS_W-1:0]    r_offset_bits;
    logic [WAYS_USED_W-1:0]      r_ways_used;
    logic [NUM_SETS-1:0]         r_row_init;
    logic [COUNT_WIDTH-1:0]      r_hit_cnt, r_miss_cnt, r_evict_cnt;
    logic                        r_out_valid;
    t_out_beat                   r_out;

    // Access held across the read
    logic [ACTION_W-1:0]         r_action;
    logic [MAX_SET_BITS-1:0]     r_set;
    logic [TAG_W-1:0]            r_tag;
    logic                        r_rd_init;

    // Set memory
    t_row                        mem [NUM_SETS];
    t_row                        r_rd_row;

    logic                        in_accept;
    logic                        finish;
    logic [MAX_SET_BITS-1:0]     set_c;
    logic [TAG_W-1:0]            tag_c;
    logic [NW_W-1:0]             nways;
    logic                        do_access;
    logic                        is_modify;

    logic [WAYS-1:0]             valid_eff;
    logic [WAYS-1:0]             in_use;
    logic [WAYS-1:0][RANK_W-1:0] rank_eff;
    logic [WAYS-1:0]             hit_vec;
    logic                        hit;
    logic [WIDX_W-1:0]           hit_way;
    logic                        inv_found;
    logic [WIDX_W-1:0]           inv_way;
    logic [WIDX_W-1:0]           lru_way;
    logic [WIDX_W-1:0]           way_sel;
    logic [RANK_W-1:0]           old_rank;
    t_row                        n_row;

    logic [1:0]                  n_hits_add;
    logic                        n_miss_add, n_evict_add;
    logic [COUNT_WIDTH:0]        hit_sum, miss_sum, evict_sum;
    logic [COUNT_WIDTH-1:0]      n_hit_cnt, n_miss_cnt, n_evict_cnt;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign finish      = (r_state == S_LOOK) && !(r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Clamp registers and split the incoming address into set and tag
    always_comb begin
        int s, b, n;
        logic [ADDR_W-1:0] shifted;
        s = int'(r_set_bits);
        b = int'(r_offset_bits);
        n = int'(r_ways_used);
        if (s < 1) s = 1;
        if (s > MAX_SET_BITS) s = MAX_SET_BITS;
        if (b < 1) b = 1;
        if (b > OFFSET_BITS_MAX) b = OFFSET_BITS_MAX;
        if (n < 1) n = 1;
        if (n > WAYS) n = WAYS;
        nways   = NW_W'(n);
        shifted = i_in_data.address >> b;
        set_c   = shifted[MAX_SET_BITS-1:0] & MAX_SET_BITS'((1 << s) - 1);
        tag_c   = TAG_W'(i_in_data.address >> (s + b));
    end

    // Lookup, victim choice and age update on the row read back
    always_comb begin
        logic [WAYS-1:0] valid_base;
        valid_base = r_rd_init ? r_rd_row.valid : '0;
        for (int j = 0; j < WAYS; j++) begin
            in_use[j]    = (j < int'(nways));
            valid_eff[j] = valid_base[j] && in_use[j];
            rank_eff[j]  = r_rd_init ? r_rd_row.rank[j] : '0;
            hit_vec[j]   = valid_eff[j] && (r_rd_row.tag[j] == r_tag);
        end
        hit = |hit_vec;

        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        lru_way   = '0;
        for (int j = WAYS - 1; j >= 0; j--) begin
            if (hit_vec[j]) hit_way = WIDX_W'(j);
            if (in_use[j] && !valid_eff[j]) begin
                inv_found = 1'b1;
                inv_way   = WIDX_W'(j);
            end
        end
        for (int j = 1; j < WAYS; j++) begin
            if (in_use[j] && rank_eff[j] > rank_eff[lru_way]) lru_way = WIDX_W'(j);
        end
        way_sel  = hit ? hit_way : (inv_found ? inv_way : lru_way);
        old_rank = rank_eff[way_sel];

        // Build the row to write back
        n_row.valid = valid_base;
        n_row.tag   = r_rd_row.tag;
        n_row.rank  = rank_eff;
        for (int j = 0; j < WAYS; j++) begin
            if (WIDX_W'(j) == way_sel) begin
                n_row.rank[j] = '0;
                if (!hit) begin
                    n_row.valid[j] = 1'b1;
                    n_row.tag[j]   = r_tag;
                end
            end else if (valid_eff[j] && rank_eff[j] < RANK_MAX &&
                         (!hit || rank_eff[j] < old_rank)) begin
                n_row.rank[j] = rank_eff[j] + 1'b1;
            end
        end
    end

    // Per-access counts and saturating totals
    always_comb begin
        do_access   = (r_action == ACT_LOAD) || (r_action == ACT_STORE) ||
                      (r_action == ACT_MODIFY);
        is_modify   = (r_action == ACT_MODIFY);
        n_hits_add  = '0;
        n_miss_add  = 1'b0;
        n_evict_add = 1'b0;
        if (do_access) begin
            // the second half of a modify always hits the line just touched
            n_hits_add  = 2'(hit) + 2'(is_modify);
            n_miss_add  = !hit;
            n_evict_add = !hit && !inv_found;
        end
        hit_sum     = {1'b0, r_hit_cnt}   + (COUNT_WIDTH + 1)'(n_hits_add);
        miss_sum    = {1'b0, r_miss_cnt}  + (COUNT_WIDTH + 1)'(n_miss_add);
        evict_sum   = {1'b0, r_evict_cnt} + (COUNT_WIDTH + 1)'(n_evict_add);
        n_hit_cnt   = hit_sum[COUNT_WIDTH]   ? COUNT_MAX : hit_sum[COUNT_WIDTH-1:0];
        n_miss_cnt  = miss_sum[COUNT_WIDTH]  ? COUNT_MAX : miss_sum[COUNT_WIDTH-1:0];
        n_evict_cnt = evict_sum[COUNT_WIDTH] ? COUNT_MAX : evict_sum[COUNT_WIDTH-1:0];
    end

    // Set memory: read on accept, write back when the access finishes
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_row <= mem[set_c];
        end
        if (finish && do_access) begin
            mem[r_set] <= n_row;
        end
    end

    // Hold the accepted access
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action  <= i_in_data.action;
            r_set     <= set_c;
            r_tag     <= tag_c;
            r_rd_init <= r_row_init[set_c];
        end
    end

    // Control, configuration, totals and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_set_bits    <= SET_BITS_RST;
            r_offset_bits <= OFFSET_BITS_RST;
            r_ways_used   <= WAYS_USED_RST;
            r_row_init    <= '0;
            r_hit_cnt     <= '0;
            r_miss_cnt    <= '0;
            r_evict_cnt   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // take configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_BITS:    r_set_bits    <= i_cfg_data[SET_BITS_W-1:0];
                    CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[OFFSET_BITS_W-1:0];
                    CFG_WAYS_USED:   r_ways_used   <= i_cfg_data[WAYS_USED_W-1:0];
                    default: ;
                endcase
            end

            // drop a result beat once taken, unless the next one loads now
            if (r_out_valid && !i_out_stall && !finish) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (finish) begin
                        r_state     <= S_IDLE;
                        r_hit_cnt   <= n_hit_cnt;
                        r_miss_cnt  <= n_miss_cnt;
                        r_evict_cnt <= n_evict_cnt;
                        if (do_access) r_row_init[r_set] <= 1'b1;
                        r_out_valid          <= 1'b1;
                        r_out.hits_added     <= n_hits_add;
                        r_out.missed         <= n_miss_add;
                        r_out.evicted        <= n_evict_add;
                        r_out.hit_total      <= TOTAL_W'(n_hit_cnt);
                        r_out.miss_total     <= TOTAL_W'(n_miss_cnt);
                        r_out.eviction_total <= TOTAL_W'(n_evict_cnt);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sim/tb_set_assoc_lru_cache_tags.sv -----
// Self-checking testbench for the set-associative LRU cache tag store.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_tags;
    import salc_pkg::*;

    localparam int NUM_SETS    = 1 << MAX_SET_BITS_DEF;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 315;
    localparam int QUIET_LIMIT = 4000;
    localparam int POOL_SIZE   = 12;

    // Codes the package leaves unnamed
    localparam logic [ACTION_W-1:0]  ACT_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Tag store, LRU ranks and totals, plus the queue of results still owed
    class lru_tag_model;
        bit                    line_valid [NUM_SETS][WAYS_DEF];
        logic [ADDR_W-1:0]     line_tag   [NUM_SETS][WAYS_DEF];
        bit [2:0]              line_rank  [NUM_SETS][WAYS_DEF];
        bit [TOTAL_W-1:0]      hits, misses, evictions;
        bit [SET_BITS_W-1:0]   set_bits_r;
        bit [OFFSET_BITS_W-1:0] offset_bits_r;
        bit [WAYS_USED_W-1:0]  ways_used_r;
        t_out_beat             owed_results [$];
        int                    errors;

        function new();
            set_bits_r    = SET_BITS_RST;
            offset_bits_r = OFFSET_BITS_RST;
            ways_used_r   = WAYS_USED_RST;
        endfunction

        function int clamp(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function int eff_set_bits();
            return clamp(int'(set_bits_r), 1, MAX_SET_BITS_DEF);
        endfunction

        function int eff_offset_bits();
            return clamp(int'(offset_bits_r), 1, OFFSET_BITS_MAX);
        endfunction

        function int eff_ways();
            return clamp(int'(ways_used_r), 1, WAYS_DEF);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SET_BITS:    set_bits_r    = data[SET_BITS_W-1:0];
                CFG_OFFSET_BITS: offset_bits_r = data[OFFSET_BITS_W-1:0];
                CFG_WAYS_USED:   ways_used_r   = data[WAYS_USED_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [TOTAL_W-1:0] sat_inc(bit [TOTAL_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        // Make way w most recent; on a hit only the ways younger than w age
        function void touch_way(int set_idx, int w, int nways, bit hit);
            bit [2:0] old_rank;
            int       j;
            old_rank = line_rank[set_idx][w];
            for (j = 0; j < nways; j++) begin
                if (j != w && line_valid[set_idx][j] &&
                    (!hit || line_rank[set_idx][j] < old_rank) &&
                    line_rank[set_idx][j] < WAYS_DEF - 1)
                    line_rank[set_idx][j]++;
            end
            line_rank[set_idx][w] = 0;
        endfunction

        // One lookup with fill or eviction; returns 1 on a hit
        function bit lookup(logic [ADDR_W-1:0] addr, output bit evicted);
            int                s, b, n, set_idx, victim, w;
            logic [ADDR_W-1:0] tag;
            bit                found;
            s       = eff_set_bits();
            b       = eff_offset_bits();
            n       = eff_ways();
            set_idx = int'((addr >> b) & ((64'd1 << s) - 64'd1));
            tag     = addr >> (s + b);
            evicted = 1'b0;
            found   = 1'b0;
            victim  = 0;
            for (w = 0; w < n; w++) begin
                if (line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
                    touch_way(set_idx, w, n, 1'b1);
                    hits = sat_inc(hits);
                    return 1'b1;
                end
            end
            misses = sat_inc(misses);
            for (w = 0; w < n; w++) begin
                if (!found && !line_valid[set_idx][w]) begin
                    victim = w;
                    found  = 1'b1;
                end
            end
            // No free way: the oldest in-use way goes, lowest index on a tie
            if (!found) begin
                for (w = 1; w < n; w++)
                    if (line_rank[set_idx][w] > line_rank[set_idx][victim])
                        victim = w;
                evicted   = 1'b1;
                evictions = sat_inc(evictions);
            end
            line_valid[set_idx][victim] = 1'b1;
            line_tag[set_idx][victim]   = tag;
            touch_way(set_idx, victim, n, 1'b0);
            return 1'b0;
        endfunction

        function void note_access(t_in_beat beat);
            t_out_beat res;
            bit        ev, ev2;
            int        hit_cnt;
            res     = '0;
            hit_cnt = 0;
            if (beat.action != ACT_NONE) begin
                if (lookup(beat.address, ev))
                    hit_cnt++;
                else begin
                    res.missed  = 1'b1;
                    res.evicted = ev;
                end
                // Second half of a modify
                if (beat.action == ACT_MODIFY && lookup(beat.address, ev2))
                    hit_cnt++;
            end
            res.hits_added     = hit_cnt[1:0];
            res.hit_total      = hits;
            res.miss_total     = misses;
            res.eviction_total = evictions;
            owed_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [TOTAL_W-1:0] want,
                                    logic [TOTAL_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, got %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: result beat %h arrived with nothing expected", $time, got);
                return;
            end
            want = owed_results.pop_front();
            compare_field("hits_added", want.hits_added, got.hits_added);
            compare_field("missed", want.missed, got.missed);
            compare_field("evicted", want.evicted, got.evicted);
            compare_field("hit_total", want.hit_total, got.hit_total);
            compare_field("miss_total", want.miss_total, got.miss_total);
            compare_field("eviction_total", want.eviction_total, got.eviction_total);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_beat              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_beat             o_out_data;

    lru_tag_model predictor;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic [ADDR_W-1:0] tag_pool [POOL_SIZE];

    // Raw register values per phase, out-of-range ones included
    int phase_set_bits [PHASES] = '{1, 8, 0, 15, 3, 2};
    int phase_offset   [PHASES] = '{1, 32, 0, 63, 6, 12};
    int phase_ways     [PHASES] = '{2, 8, 0, 15, 4, 3};

    set_assoc_lru_cache_tags dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Observe register writes and both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                predictor.write_reg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                predictor.note_access(i_in_data);
            if (o_out_valid && !i_out_stall)
                predictor.check_result(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("tb_set_assoc_lru_cache_tags: FAIL");
        $finish;
    end

    // Drive one access beat; entered and left at a falling edge
    task automatic send_access(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr);
        t_in_beat beat;
        beat.action  = act;
        beat.address = addr;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Hold the input until every owed result is back, then let the pipeline settle
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (predictor.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        @(negedge i_clk);
    endtask

    initial begin
        int                ph, k, s, b, n, span, set_idx;
        logic [ADDR_W-1:0] tag, addr, off;
        logic [ACTION_W-1:0] act;

        predictor   = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats at reset geometry: 16 sets, 16-byte lines, one way
        send_access(ACT_LOAD,   64'h0);
        send_access(ACT_LOAD,   64'h0);
        send_access(ACT_STORE,  64'hF);
        send_access(ACT_MODIFY, 64'h100);
        send_access(ACT_NONE,   64'hFFFF_FFFF_FFFF_FFFF);
        send_access(ACT_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
        send_access(ACT_STORE,  64'hFFFF_FFFF_FFFF_FFF0);
        send_access(ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(ACT_MODIFY, 64'h8000_0000_0000_0000);
        send_access(ACT_LOAD,   64'h0);
        send_access(ACT_STORE,  64'h5555_5555_5555_5555);
        send_access(ACT_LOAD,   64'hAAAA_AAAA_AAAA_AAAA);
        send_access(ACT_MODIFY, 64'h5555_5555_5555_5550);
        send_access(ACT_NONE,   64'h0);
        send_access(ACT_STORE,  64'h7FFF_FFFF_FFFF_FFFF);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph < 2) begin
                send_idle_pct  = 30;
                recv_stall_pct = 71;
            end else if (ph < 4) begin
                send_idle_pct  = 71;
                recv_stall_pct = 30;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            // Reconfigure only with the block idle
            wait_drain();
            if (ph == 0)
                cfg_write(CFG_UNUSED, $urandom_range(63));
            cfg_write(CFG_SET_BITS, phase_set_bits[ph]);
            cfg_write(CFG_OFFSET_BITS, phase_offset[ph]);
            cfg_write(CFG_WAYS_USED, phase_ways[ph]);
            i_cfg_we <= 1'b0;
            @(negedge i_clk);

            s    = predictor.eff_set_bits();
            b    = predictor.eff_offset_bits();
            n    = predictor.eff_ways();
            span = (n + 2 > POOL_SIZE) ? POOL_SIZE : n + 2;
            for (k = 0; k < POOL_SIZE; k++)
                tag_pool[k] = (k % 2 == 0) ? 64'(k) : {$urandom, $urandom};

            for (k = 0; k < PHASE_BEATS; k++) begin
                // Let the block run dry now and then
                if (k == PHASE_BEATS / 2 || $urandom_range(199) == 0)
                    wait_drain();

                if ($urandom_range(99) < 3)
                    act = ACT_NONE;
                else
                    case ($urandom_range(2))
                        0:       act = ACT_LOAD;
                        1:       act = ACT_STORE;
                        default: act = ACT_MODIFY;
                    endcase

                // Mostly a few hot sets with a small tag pool, so hits and evictions mix
                if ($urandom_range(9) == 0) begin
                    addr = {$urandom, $urandom};
                end else begin
                    tag     = tag_pool[$urandom_range(span - 1)];
                    set_idx = ($urandom_range(9) == 0) ? int'($urandom_range(255))
                                                       : int'($urandom_range(3));
                    off     = {$urandom, $urandom} & ((64'd1 << b) - 64'd1);
                    addr    = (tag << (s + b))
                            | ((64'(set_idx) & ((64'd1 << s) - 64'd1)) << b)
                            | off;
                end
                send_access(act, addr);
            end
        end

        wait_drain();
        repeat (8) @(negedge i_clk);
        if (predictor.errors == 0 && predictor.pending() == 0)
            $display("tb_set_assoc_lru_cache_tags: PASS");
        else
            $display("tb_set_assoc_lru_cache_tags: FAIL");
        $finish;
    end

endmodule
